// ===== rtl/ofb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ofb_pkg;

   // command codes of an input word
   localparam logic [1:0] CMD_HIT    = 2'd0;
   localparam logic [1:0] CMD_FINISH = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MIN_HIT   = 2'd0;
   localparam logic [1:0] CSR_MIN_FLASH = 2'd1;
   localparam logic [1:0] CSR_BIN_WIDTH = 2'd2;
   localparam logic [1:0] CSR_GATE      = 2'd3;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 29;
   localparam int CMD_W     = 2;
   localparam int CHAN_W    = 5;
   localparam int Q_W       = 16;
   localparam int T_W       = 16;
   localparam int RBIN_W    = 8;
   localparam int CHG_W     = 24;
   localparam int TOT_W     = 29;

   localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};
   localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

   localparam logic [15:0]        RST_MIN_HIT   = 16'd16;
   localparam logic [TOT_W-1:0]   RST_MIN_FLASH = 29'd160;
   localparam logic [15:0]        RST_BIN_WIDTH = 16'd100;
   localparam logic [15:0]        RST_GATE      = 16'd23400;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVG,
      ST_DISP,
      ST_DIVT,
      ST_HIT_CHK,
      ST_HIT_WR,
      ST_RD_OUT,
      ST_F_LOOP,
      ST_F_RDB,
      ST_F_CMP,
      ST_F_PW_CHK,
      ST_F_PW_TST,
      ST_F_ZERO,
      ST_F_M_RD,
      ST_F_M_WR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_BINS_SET,
      OP_DIVT_START,
      OP_BIN_SET,
      OP_HIT_RD,
      OP_HIT_WR,
      OP_RD_RD,
      OP_RD_OUT,
      OP_CLR_START,
      OP_CLR_STEP,
      OP_F_START,
      OP_F_RDA,
      OP_F_RDB,
      OP_F_CMP,
      OP_F_SEED,
      OP_F_PRD,
      OP_J_INC,
      OP_F_ZERO,
      OP_F_MRD,
      OP_F_MWR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic div_done;
      logic clr_last;
      logic hit_ok;
      logic out_full;
      logic f_end;
      logic rise;
      logic merge;
      logic j_gt_i;
      logic pnd_set;
      logic c_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/ofb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ofb_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);

   logic [16:0] rem_ff;
   logic [15:0] quo_ff;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [16:0] rem_sh;
   logic        ge;

   // one quotient bit a cycle, restoring
   always_comb begin
      rem_sh = {rem_ff[15:0], quo_ff[15]};
      ge     = rem_sh >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd16;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 17'd0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_ff <= {quo_ff[14:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/ofb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ofb_dp #(
   parameter int MAX_BINS     = 256,
   parameter int NUM_CHANNELS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ofb_pkg::dp_cmd_type            cmd,
   output ofb_pkg::dp_status_type              status,
   input  wire logic                           csr_we,
   input  wire logic [ofb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ofb_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  wire logic [ofb_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [ofb_pkg::CHAN_W-1:0]     req_hit_channel,
   input  wire logic [ofb_pkg::Q_W-1:0]        req_hit_charge,
   input  wire logic signed [ofb_pkg::T_W-1:0] req_hit_time_ns,
   input  wire logic [ofb_pkg::RBIN_W-1:0]     req_read_bin,
   input  wire logic [ofb_pkg::CHAN_W-1:0]     req_read_channel,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_flash_valid,
   output logic signed [ofb_pkg::T_W-1:0]      rsp_flash_time_ns,
   output logic [ofb_pkg::CHG_W-1:0]           rsp_channel_charge,
   output logic [ofb_pkg::TOT_W-1:0]           rsp_bin_total
);

   localparam int BIN_W     = $clog2(MAX_BINS);
   localparam int NB_W      = BIN_W + 1;
   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CA_W      = BIN_W + CH_W;
   localparam int CHG_DEPTH = MAX_BINS * (2 ** CH_W);
   localparam int CHG_W     = ofb_pkg::CHG_W;
   localparam int TOT_W     = ofb_pkg::TOT_W;
   localparam logic [16:0]     MAXB17 = 17'(MAX_BINS);
   localparam logic [8:0]      NCH9   = 9'(NUM_CHANNELS);
   localparam logic [CH_W-1:0] C_LAST = CH_W'(NUM_CHANNELS - 1);
   localparam logic [CA_W-1:0] CLR_LAST = CA_W'(CHG_DEPTH - 1);

   // memories
   logic [CHG_W-1:0] chg_mem [CHG_DEPTH];
   logic [TOT_W-1:0] tot_mem [MAX_BINS];
   logic [15:0]      pkq_mem [MAX_BINS];
   logic [15:0]      pkt_mem [MAX_BINS];
   logic             pnd_mem [MAX_BINS];

   logic [CHG_W-1:0] chg_q1, chg_q2;
   logic [TOT_W-1:0] tot_q;
   logic [15:0]      pkq_q, pkt_q;
   logic             pnd_q;

   logic             chg_we, chg_re1, chg_re2;
   logic [CA_W-1:0]  chg_waddr, chg_raddr1, chg_raddr2;
   logic [CHG_W-1:0] chg_wdata;
   logic             tot_we, tot_re;
   logic [BIN_W-1:0] tot_waddr, tot_raddr;
   logic [TOT_W-1:0] tot_wdata;
   logic             pk_we, pk_re;
   logic [BIN_W-1:0] pk_waddr, pk_raddr;
   logic [15:0]      pkq_wdata, pkt_wdata;
   logic             pnd_we, pnd_re, pnd_wdata;
   logic [BIN_W-1:0] pnd_waddr, pnd_raddr;

   // configuration
   logic [15:0]      minq_ff;
   logic [TOT_W-1:0] minf_ff;
   logic [15:0]      bw_ff;
   logic [15:0]      gate_ff;

   // latched word and working registers
   logic [1:0]       cmd_ff;
   logic [4:0]       hch_ff;
   logic [15:0]      hq_ff;
   logic [15:0]      ht_ff;
   logic [7:0]       rbin_ff;
   logic [4:0]       rch_ff;
   logic [NB_W-1:0]  bins_ff;
   logic [BIN_W-1:0] bin_ff;
   logic             hitok_ff;
   logic [BIN_W-1:0] seed_ff, i_ff, j_ff;
   logic [CH_W-1:0]  c_ff;
   logic [TOT_W-1:0] a_ff, b_ff;
   logic [CA_W-1:0]  clr_ff;

   logic             rsp_valid_ff;
   logic             out_fv_ff;
   logic [15:0]      out_t_ff;
   logic [CHG_W-1:0] out_c_ff;
   logic [TOT_W-1:0] out_tot_ff;

   // divider
   logic        div_start;
   logic [15:0] div_dividend;
   logic        div_done;
   logic [15:0] div_quot;
   logic [15:0] w_used;

   // derived
   logic [16:0]      mag17;
   logic             neg_drop;
   logic [16:0]      bins17;
   logic [NB_W-1:0]  bins_new;
   logic [8:0]       hch9, rch9;
   logic [16:0]      rbin17;
   logic [BIN_W-1:0] hbin_addr_unused;
   logic [CH_W-1:0]  hch_a, rch_a;
   logic [BIN_W-1:0] rbin_a;
   logic             hit_ok_new;
   logic             rb_ok, rc_ok;
   logic [BIN_W-1:0] i1;
   logic [24:0]      hit_chg_sum, mrg_chg_sum;
   logic [29:0]      hit_tot_sum, mrg_tot_sum;
   logic [CHG_W-1:0] hit_chg_sat, mrg_chg_sat;
   logic [TOT_W-1:0] hit_tot_sat, mrg_tot_sat;

   ofb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (w_used),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      w_used     = (bw_ff == 16'd0) ? 16'd1 : bw_ff;
      mag17      = 17'h10000 - {1'b0, ht_ff};
      neg_drop   = ht_ff[15] && (mag17 >= {1'b0, w_used});
      bins17     = {1'b0, div_quot} + 17'd1;
      bins_new   = (bins17 > MAXB17) ? NB_W'(MAX_BINS) : NB_W'(bins17);
      hch9       = 9'(hch_ff);
      rch9       = 9'(rch_ff);
      rbin17     = 17'(rbin_ff);
      hch_a      = hch9[CH_W-1:0];
      rch_a      = rch9[CH_W-1:0];
      rbin_a     = rbin17[BIN_W-1:0];
      hbin_addr_unused = bin_ff;
      hit_ok_new = (hq_ff >= minq_ff) && (hch9 < NCH9) && !neg_drop
                   && ({1'b0, div_quot} < 17'(bins_ff));
      rb_ok      = rbin17 < 17'(bins_ff);
      rc_ok      = rch9 < NCH9;
      i1         = i_ff + BIN_W'(1);

      hit_chg_sum = {1'b0, chg_q1} + 25'(hq_ff);
      hit_chg_sat = hit_chg_sum[24] ? ofb_pkg::CHG_MAX : hit_chg_sum[23:0];
      hit_tot_sum = {1'b0, tot_q} + 30'(hq_ff);
      hit_tot_sat = hit_tot_sum[29] ? ofb_pkg::TOT_MAX : hit_tot_sum[28:0];
      mrg_chg_sum = {1'b0, chg_q1} + {1'b0, chg_q2};
      mrg_chg_sat = mrg_chg_sum[24] ? ofb_pkg::CHG_MAX : mrg_chg_sum[23:0];
      mrg_tot_sum = {1'b0, tot_q} + {1'b0, b_ff};
      mrg_tot_sat = mrg_tot_sum[29] ? ofb_pkg::TOT_MAX : mrg_tot_sum[28:0];
   end

   // memory port and divider start selection
   always_comb begin
      div_start    = 1'b0;
      div_dividend = gate_ff;
      chg_we = 1'b0; chg_waddr = {CA_W{1'b0}}; chg_wdata = {CHG_W{1'b0}};
      chg_re1 = 1'b0; chg_raddr1 = {CA_W{1'b0}};
      chg_re2 = 1'b0; chg_raddr2 = {CA_W{1'b0}};
      tot_we = 1'b0; tot_waddr = {BIN_W{1'b0}}; tot_wdata = {TOT_W{1'b0}};
      tot_re = 1'b0; tot_raddr = {BIN_W{1'b0}};
      pk_we = 1'b0; pk_waddr = {BIN_W{1'b0}}; pkq_wdata = 16'd0; pkt_wdata = 16'd0;
      pk_re = 1'b0; pk_raddr = {BIN_W{1'b0}};
      pnd_we = 1'b0; pnd_waddr = {BIN_W{1'b0}}; pnd_wdata = 1'b0;
      pnd_re = 1'b0; pnd_raddr = {BIN_W{1'b0}};
      case (cmd.op)
         ofb_pkg::OP_LATCH: begin
            div_start = 1'b1;
         end
         ofb_pkg::OP_DIVT_START: begin
            div_start    = 1'b1;
            div_dividend = ht_ff[15] ? 16'd0 : ht_ff;
         end
         ofb_pkg::OP_CLR_STEP: begin
            chg_we    = 1'b1;
            chg_waddr = clr_ff;
            tot_we    = 1'b1;
            tot_waddr = clr_ff[CA_W-1:CH_W];
            pk_we     = 1'b1;
            pk_waddr  = clr_ff[CA_W-1:CH_W];
         end
         ofb_pkg::OP_HIT_RD: begin
            chg_re1    = 1'b1;
            chg_raddr1 = {bin_ff, hch_a};
            tot_re     = 1'b1;
            tot_raddr  = bin_ff;
            pk_re      = 1'b1;
            pk_raddr   = bin_ff;
         end
         ofb_pkg::OP_HIT_WR: begin
            chg_we    = 1'b1;
            chg_waddr = {bin_ff, hch_a};
            chg_wdata = hit_chg_sat;
            tot_we    = 1'b1;
            tot_waddr = bin_ff;
            tot_wdata = hit_tot_sat;
            pk_we     = pkq_q < hq_ff;
            pk_waddr  = bin_ff;
            pkq_wdata = hq_ff;
            pkt_wdata = ht_ff;
         end
         ofb_pkg::OP_RD_RD: begin
            chg_re1    = 1'b1;
            chg_raddr1 = {rbin_a, rch_a};
            tot_re     = 1'b1;
            tot_raddr  = rbin_a;
            pk_re      = 1'b1;
            pk_raddr   = rbin_a;
         end
         ofb_pkg::OP_F_RDA: begin
            tot_re    = 1'b1;
            tot_raddr = i_ff;
         end
         ofb_pkg::OP_F_RDB: begin
            tot_re    = 1'b1;
            tot_raddr = i1;
         end
         ofb_pkg::OP_F_CMP: begin
            pnd_we    = 1'b1;
            pnd_waddr = i1;
            pnd_wdata = status.merge;
         end
         ofb_pkg::OP_F_PRD: begin
            pnd_re    = 1'b1;
            pnd_raddr = j_ff;
         end
         ofb_pkg::OP_F_ZERO: begin
            chg_we    = 1'b1;
            chg_waddr = {j_ff, c_ff};
            tot_we    = (c_ff == {CH_W{1'b0}});
            tot_waddr = j_ff;
         end
         ofb_pkg::OP_F_MRD: begin
            chg_re1    = 1'b1;
            chg_raddr1 = {seed_ff, c_ff};
            chg_re2    = 1'b1;
            chg_raddr2 = {i1, c_ff};
            tot_re     = 1'b1;
            tot_raddr  = seed_ff;
         end
         ofb_pkg::OP_F_MWR: begin
            chg_we    = 1'b1;
            chg_waddr = {seed_ff, c_ff};
            chg_wdata = mrg_chg_sat;
            tot_we    = (c_ff == C_LAST);
            tot_waddr = seed_ff;
            tot_wdata = mrg_tot_sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (chg_we) chg_mem[chg_waddr] <= chg_wdata;
      if (chg_re1) chg_q1 <= chg_mem[chg_raddr1];
      if (chg_re2) chg_q2 <= chg_mem[chg_raddr2];
   end

   always_ff @(posedge clock) begin
      if (tot_we) tot_mem[tot_waddr] <= tot_wdata;
      if (tot_re) tot_q <= tot_mem[tot_raddr];
   end

   always_ff @(posedge clock) begin
      if (pk_we) begin
         pkq_mem[pk_waddr] <= pkq_wdata;
         pkt_mem[pk_waddr] <= pkt_wdata;
      end
      if (pk_re) begin
         pkq_q <= pkq_mem[pk_raddr];
         pkt_q <= pkt_mem[pk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pnd_we) pnd_mem[pnd_waddr] <= pnd_wdata;
      if (pnd_re) pnd_q <= pnd_mem[pnd_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         minq_ff <= ofb_pkg::RST_MIN_HIT;
         minf_ff <= ofb_pkg::RST_MIN_FLASH;
         bw_ff   <= ofb_pkg::RST_BIN_WIDTH;
         gate_ff <= ofb_pkg::RST_GATE;
      end else if (csr_we) begin
         case (csr_index)
            ofb_pkg::CSR_MIN_HIT:   minq_ff <= csr_wdata[15:0];
            ofb_pkg::CSR_MIN_FLASH: minf_ff <= csr_wdata;
            ofb_pkg::CSR_BIN_WIDTH: bw_ff   <= csr_wdata[15:0];
            ofb_pkg::CSR_GATE:      gate_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // control-side counters and output flag
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= {CA_W{1'b0}};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == ofb_pkg::OP_CLR_START) clr_ff <= {CA_W{1'b0}};
         else if (cmd.op == ofb_pkg::OP_CLR_STEP) clr_ff <= clr_ff + CA_W'(1);
         if (cmd.op == ofb_pkg::OP_RD_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         ofb_pkg::OP_LATCH: begin
            cmd_ff  <= req_cmd;
            hch_ff  <= req_hit_channel;
            hq_ff   <= req_hit_charge;
            ht_ff   <= req_hit_time_ns;
            rbin_ff <= req_read_bin;
            rch_ff  <= req_read_channel;
         end
         ofb_pkg::OP_BINS_SET: bins_ff <= bins_new;
         ofb_pkg::OP_BIN_SET: begin
            bin_ff   <= div_quot[BIN_W-1:0];
            hitok_ff <= hit_ok_new;
         end
         ofb_pkg::OP_RD_OUT: begin
            out_fv_ff  <= rb_ok && (tot_q > minf_ff);
            out_t_ff   <= rb_ok ? pkt_q : 16'd0;
            out_c_ff   <= (rb_ok && rc_ok) ? chg_q1 : {CHG_W{1'b0}};
            out_tot_ff <= rb_ok ? tot_q : {TOT_W{1'b0}};
         end
         ofb_pkg::OP_F_START: begin
            seed_ff <= {BIN_W{1'b0}};
            i_ff    <= {BIN_W{1'b0}};
         end
         ofb_pkg::OP_F_RDB: a_ff <= tot_q;
         ofb_pkg::OP_F_CMP: begin
            b_ff <= tot_q;
            j_ff <= seed_ff + BIN_W'(1);
            c_ff <= {CH_W{1'b0}};
            if (!status.rise && !status.merge) i_ff <= i1;
         end
         ofb_pkg::OP_F_SEED: begin
            seed_ff <= i1;
            i_ff    <= i1;
         end
         ofb_pkg::OP_F_PRD: c_ff <= {CH_W{1'b0}};
         ofb_pkg::OP_J_INC: j_ff <= j_ff + BIN_W'(1);
         ofb_pkg::OP_F_ZERO: begin
            if (c_ff == C_LAST) begin
               c_ff <= {CH_W{1'b0}};
               j_ff <= j_ff + BIN_W'(1);
            end else begin
               c_ff <= c_ff + CH_W'(1);
            end
         end
         ofb_pkg::OP_F_MWR: begin
            if (c_ff == C_LAST) begin
               c_ff <= {CH_W{1'b0}};
               i_ff <= i1;
            end else begin
               c_ff <= c_ff + CH_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.cmd      = cmd_ff;
      status.div_done = div_done;
      status.clr_last = (clr_ff == CLR_LAST);
      status.hit_ok   = hitok_ff && (hbin_addr_unused == bin_ff);
      status.out_full = rsp_valid_ff;
      status.f_end    = ({1'b0, i_ff} + NB_W'(1)) >= bins_ff;
      status.rise     = tot_q > a_ff;
      status.merge    = (tot_q < a_ff) && (tot_q != {TOT_W{1'b0}});
      status.j_gt_i   = j_ff > i_ff;
      status.pnd_set  = pnd_q;
      status.c_last   = (c_ff == C_LAST);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_flash_valid    = out_fv_ff;
   assign rsp_flash_time_ns  = out_t_ff;
   assign rsp_channel_charge = out_c_ff;
   assign rsp_bin_total      = out_tot_ff;

endmodule
`default_nettype wire

// ===== rtl/ofb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ofb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ofb_pkg::dp_status_type status,
   output ofb_pkg::dp_cmd_type        cmd
);

   ofb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ofb_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ofb_pkg::ST_CLEAR:    if (status.clr_last) state_in = ofb_pkg::ST_IDLE;
         ofb_pkg::ST_IDLE:     if (req_valid) state_in = ofb_pkg::ST_DIVG;
         ofb_pkg::ST_DIVG:     if (status.div_done) state_in = ofb_pkg::ST_DISP;
         ofb_pkg::ST_DISP: begin
            case (status.cmd)
               ofb_pkg::CMD_HIT:    state_in = ofb_pkg::ST_DIVT;
               ofb_pkg::CMD_FINISH: state_in = ofb_pkg::ST_F_LOOP;
               ofb_pkg::CMD_READ:   state_in = ofb_pkg::ST_RD_OUT;
               default:             state_in = ofb_pkg::ST_CLEAR;
            endcase
         end
         ofb_pkg::ST_DIVT:     if (status.div_done) state_in = ofb_pkg::ST_HIT_CHK;
         ofb_pkg::ST_HIT_CHK:
            state_in = status.hit_ok ? ofb_pkg::ST_HIT_WR : ofb_pkg::ST_IDLE;
         ofb_pkg::ST_HIT_WR:   state_in = ofb_pkg::ST_IDLE;
         ofb_pkg::ST_RD_OUT:   if (!status.out_full) state_in = ofb_pkg::ST_IDLE;
         ofb_pkg::ST_F_LOOP:
            state_in = status.f_end ? ofb_pkg::ST_IDLE : ofb_pkg::ST_F_RDB;
         ofb_pkg::ST_F_RDB:    state_in = ofb_pkg::ST_F_CMP;
         ofb_pkg::ST_F_CMP: begin
            if (status.rise)       state_in = ofb_pkg::ST_F_PW_CHK;
            else if (status.merge) state_in = ofb_pkg::ST_F_M_RD;
            else                   state_in = ofb_pkg::ST_F_LOOP;
         end
         ofb_pkg::ST_F_PW_CHK:
            state_in = status.j_gt_i ? ofb_pkg::ST_F_LOOP : ofb_pkg::ST_F_PW_TST;
         ofb_pkg::ST_F_PW_TST:
            state_in = status.pnd_set ? ofb_pkg::ST_F_ZERO : ofb_pkg::ST_F_PW_CHK;
         ofb_pkg::ST_F_ZERO:   if (status.c_last) state_in = ofb_pkg::ST_F_PW_CHK;
         ofb_pkg::ST_F_M_RD:   state_in = ofb_pkg::ST_F_M_WR;
         ofb_pkg::ST_F_M_WR:
            state_in = status.c_last ? ofb_pkg::ST_F_LOOP : ofb_pkg::ST_F_M_RD;
         default:              state_in = ofb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = ofb_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ofb_pkg::ST_CLEAR: cmd.op = ofb_pkg::OP_CLR_STEP;
         ofb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = ofb_pkg::OP_LATCH;
         end
         ofb_pkg::ST_DIVG: if (status.div_done) cmd.op = ofb_pkg::OP_BINS_SET;
         ofb_pkg::ST_DISP: begin
            case (status.cmd)
               ofb_pkg::CMD_HIT:    cmd.op = ofb_pkg::OP_DIVT_START;
               ofb_pkg::CMD_FINISH: cmd.op = ofb_pkg::OP_F_START;
               ofb_pkg::CMD_READ:   cmd.op = ofb_pkg::OP_RD_RD;
               default:             cmd.op = ofb_pkg::OP_CLR_START;
            endcase
         end
         ofb_pkg::ST_DIVT:    if (status.div_done) cmd.op = ofb_pkg::OP_BIN_SET;
         ofb_pkg::ST_HIT_CHK: if (status.hit_ok) cmd.op = ofb_pkg::OP_HIT_RD;
         ofb_pkg::ST_HIT_WR:  cmd.op = ofb_pkg::OP_HIT_WR;
         ofb_pkg::ST_RD_OUT:  if (!status.out_full) cmd.op = ofb_pkg::OP_RD_OUT;
         ofb_pkg::ST_F_LOOP:  if (!status.f_end) cmd.op = ofb_pkg::OP_F_RDA;
         ofb_pkg::ST_F_RDB:   cmd.op = ofb_pkg::OP_F_RDB;
         ofb_pkg::ST_F_CMP:   cmd.op = ofb_pkg::OP_F_CMP;
         ofb_pkg::ST_F_PW_CHK:
            cmd.op = status.j_gt_i ? ofb_pkg::OP_F_SEED : ofb_pkg::OP_F_PRD;
         ofb_pkg::ST_F_PW_TST: if (!status.pnd_set) cmd.op = ofb_pkg::OP_J_INC;
         ofb_pkg::ST_F_ZERO:  cmd.op = ofb_pkg::OP_F_ZERO;
         ofb_pkg::ST_F_M_RD:  cmd.op = ofb_pkg::OP_F_MRD;
         ofb_pkg::ST_F_M_WR:  cmd.op = ofb_pkg::OP_F_MWR;
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/optical_flash_binner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// optical flash binner: photodetector hits are summed per time bin and channel;
// finish merges falling bins into the preceding rising seed; read returns one
// bin's flash flag, peak time, channel charge and total; clear zeroes the store.
// one word is taken at a time. every word first runs the serial divider for the
// bin count (gate / width + 1, at most MAX_BINS); a hit adds a second division
// and a read-modify-write, which is skipped when the hit is dropped; a read
// waits while the previous response word is still waiting on rsp_stall. finish
// compares each bin pair, merges every channel of a falling bin into the seed,
// and on each rising bin checks the bins after the seed for a pending mark,
// zeroes every channel of each pending bin and takes the new seed.
// after reset and after clear a pass sweeps the charge memory, all
// MAX_BINS * 2**ceil(log2(NUM_CHANNELS)) words (8192 by default), during which
// no word is taken. a configuration write takes effect at once, so it should
// only be made while no word is in flight.
module optical_flash_binner_top #(
   parameter int MAX_BINS     = 256,
   parameter int NUM_CHANNELS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_we,
   input  wire logic [ofb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ofb_pkg::CSR_DAT_W-1:0]  csr_wdata,
   // request words
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [ofb_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [ofb_pkg::CHAN_W-1:0]     req_hit_channel,
   input  wire logic [ofb_pkg::Q_W-1:0]        req_hit_charge,
   input  wire logic signed [ofb_pkg::T_W-1:0] req_hit_time_ns,
   input  wire logic [ofb_pkg::RBIN_W-1:0]     req_read_bin,
   input  wire logic [ofb_pkg::CHAN_W-1:0]     req_read_channel,
   // response words
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_flash_valid,
   output logic signed [ofb_pkg::T_W-1:0]      rsp_flash_time_ns,
   output logic [ofb_pkg::CHG_W-1:0]           rsp_channel_charge,
   output logic [ofb_pkg::TOT_W-1:0]           rsp_bin_total
);

   // controller to datapath commands and status
   ofb_pkg::dp_cmd_type    dp_cmd;
   ofb_pkg::dp_status_type dp_status;

   ofb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // memories, divider, working registers and response register
   ofb_dp #(
      .MAX_BINS     (MAX_BINS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_cmd),
      .req_hit_channel    (req_hit_channel),
      .req_hit_charge     (req_hit_charge),
      .req_hit_time_ns    (req_hit_time_ns),
      .req_read_bin       (req_read_bin),
      .req_read_channel   (req_read_channel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_flash_valid    (rsp_flash_valid),
      .rsp_flash_time_ns  (rsp_flash_time_ns),
      .rsp_channel_charge (rsp_channel_charge),
      .rsp_bin_total      (rsp_bin_total)
   );

endmodule
`default_nettype wire
